// ===== rtl/swst_pkg.sv =====
// Shared types, constants and codes for the speed window statistics block.
package swst_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int RING_AW    = $clog2(MAX_WINDOW);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
    localparam int POS_W      = FILL_W + 1;

    localparam int CFG_W   = 7;
    localparam int SPEED_W = 16;
    localparam int KMH_W   = 18;
    localparam int MIN_W   = 22;
    localparam int MEAN_W  = 26;
    localparam int FRAC_W  = 8;
    localparam int CMP_W   = (CFG_W > FILL_W) ? CFG_W : FILL_W;

    localparam int DIV_NUM_W = MEAN_W + RING_AW;
    localparam int DIV_DEN_W = FILL_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // speed * 36 / 10 via reciprocal of ten, exact for products below 2^22
    localparam int SCL_W       = SPEED_W + 6;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam int CONV_W      = SCL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_10 = 20'd838861;

    localparam logic [CFG_W-1:0]  WIN_RESET = 7'd60;
    localparam logic [MIN_W-1:0]  MIN_RESET = 22'd2559744;
    localparam logic [MEAN_W-1:0] MEAN_MAX  = {MEAN_W{1'b1}};

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        NUM_PROD,
        NUM_CUR,
        NUM_OLD
    } num_sel_t;

    typedef struct packed {
        logic               action;
        logic               has_speed;
        logic [SPEED_W-1:0] ground_speed;
    } in_item_t;

    typedef struct packed {
        logic [KMH_W-1:0] current_kmh;
        logic [KMH_W-1:0] average_kmh;
        logic [KMH_W-1:0] max_kmh;
        logic [MIN_W-1:0] min_kmh;
    } out_item_t;

    typedef struct packed {
        logic     load_in;
        logic     clear;
        logic     conv;
        logic     prod;
        logic     rd;
        logic     div_start;
        num_sel_t num_sel;
        logic     take_q1;
        logic     commit;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic action;
        logic has_speed;
        logic warm;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== rtl/swst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swst_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/swst_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module swst_div
    import swst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    always_comb
    begin
        trial = {rem_reg, num_reg[DIV_NUM_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
        if (qbit)
        begin
            rem_next = DIV_DEN_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[DIV_DEN_W-1:0];
        end
        num_next = {num_reg[DIV_NUM_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ===== rtl/swst_dp.sv =====
// Datapath: statistics registers, sample ring, conversion and mean update.
module swst_dp
    import swst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  in_item_t         in_data,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    output out_item_t        out_data
);

    logic [CFG_W-1:0]     win_reg;
    in_item_t             item_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [RING_AW-1:0]   head_reg;
    logic [MEAN_W-1:0]    mean_reg, mean_next;
    logic [KMH_W-1:0]     latest_reg;
    logic [KMH_W-1:0]     peak_reg;
    logic [MIN_W-1:0]     floor_reg;
    logic [KMH_W-1:0]     cur_reg, cur_next;
    logic [DIV_NUM_W-1:0] prod_reg;
    logic [MEAN_W-1:0]    q1_reg;
    out_item_t            out_reg;

    logic [CMP_W-1:0]     win_ext;
    logic [FILL_W-1:0]    eff_n;
    logic                 warm;
    logic [SCL_W-1:0]     scaled;
    logic [CONV_W-1:0]    conv_prod;
    logic [POS_W-1:0]     pos_sum;
    logic [RING_AW-1:0]   wr_addr;
    logic [RING_AW-1:0]   head_inc;
    logic [KMH_W-1:0]     ram_rd;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [MEAN_W-1:0]    q2;
    logic [MEAN_W-1:0]    mean_base;
    logic [MEAN_W:0]      mean_sum;

    // effective window: zero acts as one, clamp to ring depth
    always_comb
    begin
        win_ext = CMP_W'(win_reg);
        if (win_ext == '0)
        begin
            eff_n = FILL_W'(1);
        end
        else if (win_ext > CMP_W'(MAX_WINDOW))
        begin
            eff_n = FILL_W'(MAX_WINDOW);
        end
        else
        begin
            eff_n = FILL_W'(win_ext);
        end
        warm = (fill_reg < eff_n);
    end

    always_comb
    begin
        scaled    = (SCL_W'(item_reg.ground_speed) << 5) + (SCL_W'(item_reg.ground_speed) << 2);
        conv_prod = CONV_W'(scaled) * CONV_W'(RECIP_10);
        cur_next  = conv_prod[RECIP_SHIFT +: KMH_W];
    end

    always_comb
    begin
        pos_sum = POS_W'(head_reg) + POS_W'(fill_reg);
        if (pos_sum >= POS_W'(MAX_WINDOW))
        begin
            pos_sum = pos_sum - POS_W'(MAX_WINDOW);
        end
        wr_addr = pos_sum[RING_AW-1:0];
        if (head_reg == RING_AW'(MAX_WINDOW - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.num_sel)
            NUM_PROD: div_num = prod_reg;
            NUM_OLD:  div_num = DIV_NUM_W'({ram_rd, FRAC_W'(0)});
            default:  div_num = DIV_NUM_W'({cur_reg, FRAC_W'(0)});
        endcase
        div_den = warm ? (fill_reg + 1'b1) : eff_n;
    end

    always_comb
    begin
        q2 = div_quot[MEAN_W-1:0];
        if (warm)
        begin
            mean_base = q1_reg;
        end
        else if (mean_reg > q1_reg)
        begin
            mean_base = mean_reg - q1_reg;
        end
        else
        begin
            mean_base = '0;
        end
        mean_sum  = {1'b0, mean_base} + {1'b0, q2};
        mean_next = mean_sum[MEAN_W] ? MEAN_MAX : mean_sum[MEAN_W-1:0];
    end

    swst_ram #(
        .WIDTH (KMH_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (wr_addr),
        .wdata (cur_reg),
        .re    (cmd.rd),
        .raddr (head_reg),
        .rdata (ram_rd)
    );

    swst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= WIN_RESET;
            fill_reg   <= '0;
            head_reg   <= '0;
            mean_reg   <= '0;
            latest_reg <= '0;
            peak_reg   <= '0;
            floor_reg  <= MIN_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                win_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                fill_reg  <= '0;
                head_reg  <= '0;
                mean_reg  <= '0;
                peak_reg  <= '0;
                floor_reg <= MIN_RESET;
            end
            else if (cmd.commit)
            begin
                mean_reg   <= mean_next;
                latest_reg <= cur_reg;
                if (warm)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                else
                begin
                    head_reg <= head_inc;
                end
                if (cur_reg > peak_reg)
                begin
                    peak_reg <= cur_reg;
                end
                if (MIN_W'(cur_reg) < floor_reg)
                begin
                    floor_reg <= MIN_W'(cur_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            item_reg <= in_data;
        end
        if (cmd.conv)
        begin
            cur_reg <= cur_next;
        end
        if (cmd.prod)
        begin
            prod_reg <= DIV_NUM_W'(mean_reg) * DIV_NUM_W'(fill_reg[RING_AW-1:0]);
        end
        if (cmd.take_q1)
        begin
            q1_reg <= div_quot[MEAN_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_reg.current_kmh <= latest_reg;
            out_reg.average_kmh <= mean_reg[MEAN_W-1:FRAC_W];
            out_reg.max_kmh     <= peak_reg;
            out_reg.min_kmh     <= floor_reg;
        end
    end

    assign stat.action    = item_reg.action;
    assign stat.has_speed = item_reg.has_speed;
    assign stat.warm      = warm;
    assign stat.div_done  = div_done;
    assign out_data       = out_reg;

endmodule

// ===== rtl/swst_ctrl.sv =====
// Controller: steps one beat through clear, or conversion, divisions and update.
module swst_ctrl
    import swst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_PROD,
        S_READ,
        S_DIV_A,
        S_WAIT_A,
        S_DIV_B,
        S_WAIT_B,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.num_sel    = NUM_CUR;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.action == ACT_CLEAR)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_FIN;
                end
                else if (!stat.has_speed)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.conv   = 1'b1;
                    state_next = stat.warm ? S_PROD : S_READ;
                end
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_DIV_A;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DIV_A;
            end
            S_DIV_A:
            begin
                cmd.div_start = 1'b1;
                cmd.num_sel   = stat.warm ? NUM_PROD : NUM_OLD;
                state_next    = S_WAIT_A;
            end
            S_WAIT_A:
            begin
                if (stat.div_done)
                begin
                    cmd.take_q1 = 1'b1;
                    state_next  = S_DIV_B;
                end
            end
            S_DIV_B:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                if (stat.div_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/speed_window_stats.sv =====
// Speed window statistics: km/h conversion, windowed moving mean, max and min.
//
// One beat in gives one beat out. The bit-serial divider runs twice per
// speed sample and sets how long a sample takes; a statistics-clear beat or
// a beat without speed skips the divisions. One beat is processed at a time,
// while the previous result may still wait in the output register. The window
// register is written through the cfg port, which is always ready.
module speed_window_stats
    import swst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    swst_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

    swst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input beat accepted while another is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("output register loaded while a stalled beat waits");

    a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.min_kmh <= MIN_RESET))
        else $error("minimum above its reset value");

    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear && cmd.commit))
        else $error("clear and commit in the same cycle");

endmodule

// ===== verif/speed_window_stats_tb.sv =====
// Self-checking testbench for speed_window_stats: directed table, random beats, running predictor.
module speed_window_stats_tb;
    import swst_pkg::*;

    localparam int WATCHDOG_LIMIT       = 4000;
    localparam int DRAIN_CYCLES         = 200;
    localparam int RAND_ITEMS_PER_PHASE = 642;

    logic            clk;
    logic            rst_n;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic            in_valid;
    logic            in_stall;
    in_item_t        in_data;
    logic            out_valid;
    logic            out_stall;
    out_item_t       out_data;

    speed_window_stats u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg;
        in_item_t         item;
        bit               known;
        out_item_t        exp;
    } stim_row_t;

    // predictor state
    logic [KMH_W-1:0]   win_ring [MAX_WINDOW];
    logic [FILL_W-1:0]  win_fill;
    logic [RING_AW-1:0] win_head;
    logic [MEAN_W-1:0]  mean_fx;
    logic [KMH_W-1:0]   last_kmh;
    logic [KMH_W-1:0]   peak_kmh;
    logic [MIN_W-1:0]   floor_kmh;
    logic [CFG_W-1:0]   win_len_reg;

    out_item_t stats_expected [$];
    stim_row_t directed_rows [$];
    int        mismatch_count;
    int        beat_count;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;

    function automatic out_item_t update_speed_stats(input in_item_t item);
        out_item_t          res;
        longint unsigned    gs64;
        longint unsigned    cur64;
        longint unsigned    old64;
        longint unsigned    n;
        longint unsigned    c;
        longint unsigned    curf;
        longint             m;
        longint             old_part;
        longint             new_part;
        logic [RING_AW-1:0] pos;
        if (item.action == ACT_CLEAR) begin
            win_fill  = '0;
            win_head  = '0;
            mean_fx   = '0;
            peak_kmh  = '0;
            floor_kmh = MIN_RESET;
        end
        else if (item.has_speed) begin
            gs64  = 64'(item.ground_speed);
            cur64 = (gs64 * 36) / 10;
            curf  = cur64 << FRAC_W;
            if (win_len_reg == 0)
                n = 1;
            else if (win_len_reg > MAX_WINDOW)
                n = 64'(MAX_WINDOW);
            else
                n = 64'(win_len_reg);
            last_kmh = KMH_W'(cur64);
            if (win_fill < n) begin
                pos = win_head + win_fill[RING_AW-1:0];
                win_ring[pos] = KMH_W'(cur64);
                win_fill = win_fill + 1'b1;
                c = 64'(win_fill);
                m = (mean_fx * (c - 1)) / c + curf / c;
            end
            else begin
                old64 = 64'(win_ring[win_head]);
                pos = win_head + win_fill[RING_AW-1:0];
                old_part = (old64 << FRAC_W) / n;
                new_part = curf / n;
                m = 64'(mean_fx);
                m = m - old_part;
                if (m < 0)
                    m = 0;
                m = m + new_part;
                win_ring[pos] = KMH_W'(cur64);
                win_head = win_head + 1'b1;
            end
            if (m < 0)
                m = 0;
            if (m > longint'(MEAN_MAX))
                m = longint'(MEAN_MAX);
            mean_fx = MEAN_W'(m);
            if (KMH_W'(cur64) > peak_kmh)
                peak_kmh = KMH_W'(cur64);
            if (MIN_W'(cur64) < floor_kmh)
                floor_kmh = MIN_W'(cur64);
        end
        res.current_kmh = last_kmh;
        res.average_kmh = mean_fx[MEAN_W-1:FRAC_W];
        res.max_kmh     = peak_kmh;
        res.min_kmh     = floor_kmh;
        return res;
    endfunction

    function automatic stim_row_t dir_item(input logic a, input logic h,
                                           input logic [SPEED_W-1:0] g);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.cfg    = '0;
        row.item   = {a, h, g};
        row.known  = 1'b0;
        row.exp    = '0;
        return row;
    endfunction

    function automatic stim_row_t dir_known(input logic a, input logic h,
                                            input logic [SPEED_W-1:0] g,
                                            input logic [KMH_W-1:0] cur,
                                            input logic [KMH_W-1:0] avg,
                                            input logic [KMH_W-1:0] mx,
                                            input logic [MIN_W-1:0] mn);
        stim_row_t row;
        row       = dir_item(a, h, g);
        row.known = 1'b1;
        row.exp   = {cur, avg, mx, mn};
        return row;
    endfunction

    function automatic stim_row_t dir_cfg(input logic [CFG_W-1:0] len);
        stim_row_t row;
        row        = dir_item(ACT_SAMPLE, 1'b0, '0);
        row.is_cfg = 1'b1;
        row.cfg    = len;
        return row;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t item;
        int       r;
        int       k;
        r = $urandom_range(99);
        item.ground_speed = SPEED_W'($urandom);
        if (r < 4) begin
            item.action    = ACT_CLEAR;
            item.has_speed = 1'($urandom);
        end
        else if (r < 12) begin
            item.action    = ACT_SAMPLE;
            item.has_speed = 1'b0;
        end
        else begin
            item.action    = ACT_SAMPLE;
            item.has_speed = 1'b1;
            k = $urandom_range(9);
            if (k == 0)
                item.ground_speed = '0;
            else if (k == 1)
                item.ground_speed = '1;
            else if (k < 4)
                item.ground_speed = SPEED_W'($urandom_range(255));
        end
        return item;
    endfunction

    function automatic logic [CFG_W-1:0] pick_window();
        int k;
        k = $urandom_range(9);
        if (k < 5)
            return CFG_W'($urandom_range(1, 8));
        else if (k == 5)
            return CFG_W'(MAX_WINDOW);
        else if (k == 6)
            return '0;
        else if (k == 7)
            return CFG_W'($urandom_range(MAX_WINDOW + 1, 127));
        return CFG_W'($urandom_range(1, MAX_WINDOW));
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", beat_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [MIN_W-1:0] got,
                               input logic [MIN_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input in_item_t item, input bit known, input out_item_t known_exp);
        out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        predicted = update_speed_stats(item);
        stats_expected.push_back(known ? known_exp : predicted);
        @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] len);
        in_valid <= 1'b0;
        while (stats_expected.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        win_len_reg = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (stats_expected.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end
            else begin
                want = stats_expected.pop_front();
                check_field("current_kmh", MIN_W'(out_data.current_kmh), MIN_W'(want.current_kmh));
                check_field("average_kmh", MIN_W'(out_data.average_kmh), MIN_W'(want.average_kmh));
                check_field("max_kmh", MIN_W'(out_data.max_kmh), MIN_W'(want.max_kmh));
                check_field("min_kmh", out_data.min_kmh, want.min_kmh);
            end
            beat_count++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int sent;
        int burst;
        stim_row_t row;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        mismatch_count = 0;
        beat_count     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 25;
        recv_idle_pct  = 50;
        win_fill       = '0;
        win_head       = '0;
        mean_fx        = '0;
        last_kmh       = '0;
        peak_kmh       = '0;
        floor_kmh      = MIN_RESET;
        win_len_reg    = WIN_RESET;

        directed_rows.push_back(dir_known(ACT_SAMPLE, 1'b0, 16'hFFFF, '0, '0, '0, MIN_RESET));
        directed_rows.push_back(dir_known(ACT_SAMPLE, 1'b1, 16'h0000, '0, '0, '0, '0));
        directed_rows.push_back(dir_known(ACT_CLEAR, 1'b1, 16'hFFFF, '0, '0, '0, MIN_RESET));
        directed_rows.push_back(dir_known(ACT_SAMPLE, 1'b1, 16'hFFFF,
                                          18'd235926, 18'd235926, 18'd235926, 22'd235926));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h0000));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h0001));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h8000));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b0, 16'h1234));
        // shrink below fill
        directed_rows.push_back(dir_cfg(7'd1));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'hFFFF));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h0000));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h00FF));
        directed_rows.push_back(dir_item(ACT_CLEAR, 1'b0, 16'h0000));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h7FFF));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'hAAAA));
        directed_rows.push_back(dir_cfg(7'd0));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h5555));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'hFFFF));
        directed_rows.push_back(dir_cfg(7'd127));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'hFFFF));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h0000));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'hFFFE));
        directed_rows.push_back(dir_cfg(7'd64));
        directed_rows.push_back(dir_item(ACT_CLEAR, 1'b1, 16'h5555));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h0100));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'hFFFF));
        directed_rows.push_back(dir_cfg(7'd2));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h0003));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'hFFFF));
        directed_rows.push_back(dir_item(ACT_SAMPLE, 1'b1, 16'h0000));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
                write_window(row.cfg);
            else
                send_beat(row.item, row.known, row.exp);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 0) begin
                send_idle_pct = 25;
                recv_idle_pct = 50;
            end
            else if (ph == 1) begin
                send_idle_pct = 50;
                recv_idle_pct = 25;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sent = 0;
            while (sent < RAND_ITEMS_PER_PHASE)
            begin
                write_window(pick_window());
                burst = $urandom_range(20, 100);
                for (int b = 0; b < burst && sent < RAND_ITEMS_PER_PHASE; b++)
                begin
                    send_beat(rand_item(), 1'b0, '0);
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        while (stats_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
